[rtl/telnet_iac_stream_filter_top_macros.svh]
// assertion macros shared by the checker
`ifndef TELNET_IAC_STREAM_FILTER_TOP_MACROS_SVH
`define TELNET_IAC_STREAM_FILTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TISF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tisf check failed");

// next-cycle implication
`define TISF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tisf check failed");

`endif

[rtl/tisf_pkg.sv]
// package: telnet filter byte codes, phases and parser result type
package tisf_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_CR   = 8'd13;
	localparam logic [7:0] B_LF   = 8'd10;
	localparam logic [7:0] B_NUL  = 8'd0;

	localparam logic [7:0] ECHO_OPTION = 8'd1;
	localparam logic [7:0] OPT_NOGA    = 8'd3;
	localparam logic [7:0] OPT_WINDOW  = 8'd31;

	localparam logic [2:0] VALUE_FULL = 3'd4;

	typedef enum logic [2:0] {
		PH_PLAIN  = 3'd0,
		PH_CR     = 3'd1,
		PH_IAC    = 3'd2,
		PH_VERB   = 3'd3,
		PH_SBOPT  = 3'd4,
		PH_SBDATA = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		VERB_DO   = 2'd0,
		VERB_DONT = 2'd1,
		VERB_WILL = 2'd2,
		VERB_WONT = 2'd3
	} verb_t;

	typedef enum logic [1:0] {
		KIND_PROGRAM = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_WINDOW  = 2'd2
	} kind_t;

	// results produced by one received byte
	typedef struct packed {
		logic [1:0]  cnt;
		kind_t       kind;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [15:0] cols;
		logic [15:0] rows;
	} result_t;

	function automatic logic [7:0] reply_code(verb_t verb, logic [7:0] opt);
		logic [7:0] r;
		case (verb)
			VERB_DO:   r = (opt == ECHO_OPTION || opt == OPT_NOGA) ? B_WILL : B_WONT;
			VERB_DONT: r = B_WONT;
			VERB_WILL: r = (opt == OPT_NOGA || opt == OPT_WINDOW) ? B_DO : B_DONT;
			default:   r = B_DONT;
		endcase
		return r;
	endfunction

endpackage

[rtl/telnet_iac_stream_filter_top.sv]
// top level: telnet receive filter with parser and result buffer
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------------
//   rx       | rx_valid, rx_stall | rx_byte, end_of_buffer
//   res      | res_valid, res_stall | result_kind, out_byte, window_columns,
//            |                    | window_rows, last_of_run
//
// one received byte is taken per cycle unless stalled; its results sit in a three-slot
// result register and leave one per cycle unless res is stalled, so a negotiation reply
// stalls rx; the next byte is taken in the cycle the last result of the previous one
// leaves; reset returns the parser to plain data with an empty result register
// a stall on res holds the shown result and, once the last one is waiting, stalls rx
module telnet_iac_stream_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_buffer,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] window_columns,
	output logic [15:0] window_rows,
	output logic        last_of_run
);

	tisf_pkg::result_t res;
	logic              accept;
	logic              take;

	logic [1:0]        rem_q;
	tisf_pkg::kind_t   kind_q;
	logic [7:0]        byte0_q, byte1_q, byte2_q;
	logic [15:0]       cols_q, rows_q;
	logic              is_window;

	tisf_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (rx_byte),
		.end_of_buffer (end_of_buffer),
		.res           (res)
	);

	assign take     = res_valid && !res_stall;
	assign rx_stall = (rem_q > 2'd1) || (rem_q == 2'd1 && res_stall);
	assign accept   = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= res.cnt;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// result payload, shifted down as each result leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= res.kind;
			byte0_q <= res.byte0;
			byte1_q <= res.byte1;
			byte2_q <= res.byte2;
			cols_q  <= res.cols;
			rows_q  <= res.rows;
		end else if (take) begin
			byte0_q <= byte1_q;
			byte1_q <= byte2_q;
		end
	end

	assign is_window      = (kind_q == tisf_pkg::KIND_WINDOW);
	assign res_valid      = (rem_q != 2'd0);
	assign last_of_run    = (rem_q == 2'd1);
	assign result_kind    = kind_q;
	assign out_byte       = is_window ? 8'd0 : byte0_q;
	assign window_columns = is_window ? cols_q : 16'd0;
	assign window_rows    = is_window ? rows_q : 16'd0;

endmodule

[rtl/tisf_parser.sv]
// telnet byte parser: phase state, subnegotiation capture and result generation
module tisf_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  logic                  end_of_buffer,
	output tisf_pkg::result_t     res
);

	tisf_pkg::phase_t ph_q, ph_d;
	tisf_pkg::verb_t  verb_q, verb_d;
	logic             win_q, win_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [31:0]      val_q, val_d;
	logic             iac_q, iac_d;

	logic             push1, push2;
	logic [7:0]       push1_byte;
	logic [2:0]       cnt1;
	logic [31:0]      val1;

	// next state
	always_comb begin
		ph_d       = ph_q;
		verb_d     = verb_q;
		win_d      = win_q;
		iac_d      = iac_q;
		push1      = 1'b0;
		push2      = 1'b0;
		push1_byte = rx_byte;
		case (ph_q)
			tisf_pkg::PH_CR: begin
				if (rx_byte == tisf_pkg::B_LF || rx_byte == tisf_pkg::B_NUL) begin
					ph_d = tisf_pkg::PH_PLAIN;
				end else if (rx_byte == tisf_pkg::B_CR) begin
					ph_d = tisf_pkg::PH_CR;
				end else if (rx_byte == tisf_pkg::B_IAC) begin
					ph_d = tisf_pkg::PH_IAC;
				end else begin
					ph_d = tisf_pkg::PH_PLAIN;
				end
			end
			tisf_pkg::PH_IAC: begin
				ph_d = tisf_pkg::PH_PLAIN;
				if (rx_byte inside {tisf_pkg::B_DO, tisf_pkg::B_DONT,
						tisf_pkg::B_WILL, tisf_pkg::B_WONT}) begin
					verb_d = (rx_byte == tisf_pkg::B_DO)   ? tisf_pkg::VERB_DO :
					         (rx_byte == tisf_pkg::B_DONT) ? tisf_pkg::VERB_DONT :
					         (rx_byte == tisf_pkg::B_WILL) ? tisf_pkg::VERB_WILL :
					                                         tisf_pkg::VERB_WONT;
					ph_d = tisf_pkg::PH_VERB;
				end else if (rx_byte == tisf_pkg::B_SB) begin
					win_d = 1'b0;
					iac_d = 1'b0;
					ph_d  = tisf_pkg::PH_SBOPT;
				end
			end
			tisf_pkg::PH_VERB: begin
				ph_d = tisf_pkg::PH_PLAIN;
			end
			tisf_pkg::PH_SBOPT: begin
				win_d = (rx_byte == tisf_pkg::OPT_WINDOW);
				iac_d = (rx_byte == tisf_pkg::B_IAC);
				ph_d  = tisf_pkg::PH_SBDATA;
			end
			tisf_pkg::PH_SBDATA: begin
				if (iac_q) begin
					iac_d = 1'b0;
					if (rx_byte == tisf_pkg::B_SE) begin
						ph_d = tisf_pkg::PH_PLAIN;
					end else if (rx_byte == tisf_pkg::B_IAC) begin
						push1 = 1'b1;
					end else begin
						// lone iac inside data counts as a value byte itself
						push1      = 1'b1;
						push1_byte = tisf_pkg::B_IAC;
						push2      = 1'b1;
					end
				end else if (rx_byte == tisf_pkg::B_IAC) begin
					iac_d = 1'b1;
				end else begin
					push1 = 1'b1;
				end
			end
			default: begin
				if (rx_byte == tisf_pkg::B_CR) begin
					ph_d = tisf_pkg::PH_CR;
				end else if (rx_byte == tisf_pkg::B_IAC) begin
					ph_d = tisf_pkg::PH_IAC;
				end else begin
					ph_d = tisf_pkg::PH_PLAIN;
				end
			end
		endcase
		if (end_of_buffer) begin
			ph_d  = tisf_pkg::PH_PLAIN;
			iac_d = 1'b0;
		end
	end

	// value capture, up to two bytes a step, saturating at four
	always_comb begin
		val1 = val_q;
		cnt1 = cnt_q;
		if (push1 && cnt_q < tisf_pkg::VALUE_FULL) begin
			val1 = {val_q[23:0], push1_byte};
			cnt1 = cnt_q + 3'd1;
		end
		val_d = val1;
		cnt_d = cnt1;
		if (push2 && cnt1 < tisf_pkg::VALUE_FULL) begin
			val_d = {val1[23:0], rx_byte};
			cnt_d = cnt1 + 3'd1;
		end
		if (ph_q == tisf_pkg::PH_IAC && rx_byte == tisf_pkg::B_SB) begin
			val_d = '0;
			cnt_d = '0;
		end
	end

	// results
	always_comb begin
		res       = '0;
		res.kind  = tisf_pkg::KIND_PROGRAM;
		res.byte0 = rx_byte;
		case (ph_q)
			tisf_pkg::PH_CR: begin
				if (rx_byte == tisf_pkg::B_CR) begin
					res.cnt   = 2'd1;
					res.byte0 = tisf_pkg::B_LF;
				end else if (rx_byte != tisf_pkg::B_LF && rx_byte != tisf_pkg::B_NUL &&
						rx_byte != tisf_pkg::B_IAC) begin
					res.cnt = 2'd1;
				end
			end
			tisf_pkg::PH_IAC: begin
				if (rx_byte == tisf_pkg::B_IAC) begin
					res.cnt = 2'd1;
				end
			end
			tisf_pkg::PH_VERB: begin
				res.cnt   = 2'd3;
				res.kind  = tisf_pkg::KIND_REPLY;
				res.byte0 = tisf_pkg::B_IAC;
				res.byte1 = tisf_pkg::reply_code(verb_q, rx_byte);
				res.byte2 = rx_byte;
			end
			tisf_pkg::PH_SBOPT: begin
				res.cnt = 2'd0;
			end
			tisf_pkg::PH_SBDATA: begin
				if (iac_q && rx_byte == tisf_pkg::B_SE && win_q &&
						cnt_q >= tisf_pkg::VALUE_FULL &&
						val_q[31:16] != 16'd0 && val_q[15:0] != 16'd0) begin
					res.cnt   = 2'd1;
					res.kind  = tisf_pkg::KIND_WINDOW;
					res.byte0 = 8'd0;
					res.cols  = val_q[31:16];
					res.rows  = val_q[15:0];
				end
			end
			default: begin
				if (rx_byte == tisf_pkg::B_CR) begin
					res.cnt   = 2'd1;
					res.byte0 = tisf_pkg::B_LF;
				end else if (rx_byte != tisf_pkg::B_IAC) begin
					res.cnt = 2'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= tisf_pkg::PH_PLAIN;
			verb_q <= tisf_pkg::VERB_DO;
			win_q  <= 1'b0;
			cnt_q  <= '0;
			val_q  <= '0;
			iac_q  <= 1'b0;
		end else if (accept) begin
			ph_q   <= ph_d;
			verb_q <= verb_d;
			win_q  <= win_d;
			cnt_q  <= cnt_d;
			val_q  <= val_d;
			iac_q  <= iac_d;
		end
	end

endmodule

[rtl/tisf_checker.sv]
// port-level checker for the telnet filter, bound to the top level
`include "telnet_iac_stream_filter_top_macros.svh"

module tisf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_stall,
	input logic [7:0]  rx_byte,
	input logic        end_of_buffer,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  result_kind,
	input logic [7:0]  out_byte,
	input logic [15:0] window_columns,
	input logic [15:0] window_rows,
	input logic        last_of_run
);

	// a stalled result transaction holds
	`TISF_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
		res_valid && $stable(result_kind) && $stable(out_byte) && $stable(last_of_run))

	// window update is a lone result with both sizes nonzero
	`TISF_ASSERT_NOW(a_window_shape, res_valid && result_kind == tisf_pkg::KIND_WINDOW,
		last_of_run && out_byte == 8'd0 && window_columns != 16'd0 && window_rows != 16'd0)

	// byte results carry no window size
	`TISF_ASSERT_NOW(a_byte_no_size, res_valid && (result_kind == tisf_pkg::KIND_PROGRAM
		|| result_kind == tisf_pkg::KIND_REPLY), window_columns == 16'd0 && window_rows == 16'd0)

	// the last result leaving frees the rx side
	`TISF_ASSERT_NOW(a_stall_release, res_valid && last_of_run && !res_stall, !rx_stall)

	// stall only while results wait
	`TISF_ASSERT_NOW(a_stall_cause, rx_stall, res_valid)

endmodule

bind telnet_iac_stream_filter_top tisf_checker u_tisf_checker (.*);
